// ----- src/elh_pkg.sv -----
// shared types and constants of the exponential latency histogram
package elh_pkg;

   localparam int CNT_W = 64;
   localparam int IDX_W = 14;
   localparam int CLS_W = 3;
   localparam int LIM_W = 9;
   localparam int EXP_W = 11;
   localparam int FRAC_W = 52;

   typedef enum logic [CLS_W-1:0] {
      CLS_BUCKET = 3'd0,
      CLS_NONPOS = 3'd1,
      CLS_SMALL  = 3'd2,
      CLS_INF    = 3'd3,
      CLS_LARGE  = 3'd4
   } class_type;

   typedef enum logic {
      CMD_OBSERVE = 1'b0,
      CMD_QUERY   = 1'b1
   } cmd_type;

   // mantissa fractions of 2^(-1/4), 2^(-1/2), 2^(-3/4)
   localparam logic [FRAC_W-1:0] TH_QUARTER = 52'hAE89F995AD3AD;
   localparam logic [FRAC_W-1:0] TH_HALF    = 52'h6A09E667F3BCD;
   localparam logic [FRAC_W-1:0] TH_THREE   = 52'h306FE0A31B715;

   localparam logic [EXP_W-1:0] EXP_MAX = 11'h7FF;
   localparam logic [63:0] POS_INF = 64'h7FF0000000000000;

   typedef struct packed {
      logic start;
      logic [63:0] acc;
      logic [63:0] smp;
   } add_req_type;

   typedef struct packed {
      logic done;
      logic [63:0] result;
   } add_rsp_type;

endpackage

// ----- src/elh_if.sv -----
// request and response channel interfaces
interface elh_req_if;
   logic valid;
   logic ready;
   logic cmd;
   logic [63:0] sample_bits;
   logic signed [8:0] grid_limit;
   modport source (output valid, cmd, sample_bits, grid_limit, input ready);
   modport sink (input valid, cmd, sample_bits, grid_limit, output ready);
endinterface

interface elh_rsp_if;
   logic valid;
   logic ready;
   logic [2:0] sample_class;
   logic signed [13:0] bucket_index;
   logic [63:0] cumulative_count;
   logic [63:0] total_count;
   logic [63:0] underflow_count;
   logic [63:0] overflow_count;
   logic [63:0] nonpositive_count;
   logic [63:0] sum_bits;
   modport source (output valid, sample_class, bucket_index, cumulative_count, total_count,
                   underflow_count, overflow_count, nonpositive_count, sum_bits,
                   input ready);
   modport sink (input valid, sample_class, bucket_index, cumulative_count, total_count,
                 underflow_count, overflow_count, nonpositive_count, sum_bits,
                 output ready);
endinterface

// ----- src/exponential_latency_histogram.sv -----
// top level of the exponential latency histogram
//
// request channel req_chan: cmd 0 observes the double in sample_bits, cmd 1 queries
// the underflow count plus all buckets with grid index below grid_limit.
// response channel rsp_chan: one word for every request word, carrying the class
// and grid index of an observed sample or the cumulative count of a query, and
// the running totals and double sum after that request.
// one request is processed at a time; the next word can be taken in the cycle after the
// response register is loaded. an observe passes through the four-stage double adder
// and the bucket read-modify-write before it reaches the response register; a sample
// that is not summed (nonpositive, nan or infinite) skips the wait on the adder, and a
// subnormal sample first goes through mantissa normalization.
// a query walks the bucket memory one entry per cycle over the
// clamp(grid_limit) - MIN_INDEX entries that lie below the limit, if any.
// after reset the bucket memory is cleared one entry per cycle, and no request is
// accepted until every entry is cleared.
// the response sits in an output register; while the receiver stalls the next
// request is still taken and processed, and waits for that register to free up.
module exponential_latency_histogram #(
   parameter int MIN_INDEX = -64,
   parameter int MAX_INDEX = 64
) (
   input logic clock,
   input logic reset,
   elh_req_if.sink req_chan,
   elh_rsp_if.source rsp_chan
);
   import elh_pkg::*;

   localparam int NUM = MAX_INDEX - MIN_INDEX;
   localparam int AW = NUM > 1 ? $clog2(NUM) : 1;
   localparam logic signed [IDX_W-1:0] MIN_I = IDX_W'(MIN_INDEX);
   localparam logic signed [IDX_W-1:0] MAX_I = IDX_W'(MAX_INDEX);
   localparam logic [AW:0] NUM_C = (AW + 1)'(NUM);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_NORM, ST_CLASSIFY, ST_UPDATE, ST_SUM, ST_WALK, ST_OUT
   } state_type;

   state_type state_ff;
   logic [AW:0] clear_ff;
   logic [63:0] bits_ff;
   logic signed [LIM_W-1:0] limit_ff;
   logic [FRAC_W-1:0] norm_ff;
   logic [5:0] shift_ff;
   class_type class_ff;
   logic signed [IDX_W-1:0] idx_ff;
   logic [AW-1:0] addr_ff;
   logic [AW:0] left_ff;
   logic rd_vld_ff;
   logic adding_ff;
   logic [CNT_W-1:0] cum_ff, total_ff, below_ff, above_ff, nonpos_ff;
   logic [63:0] sum_ff;

   logic rsp_valid_ff;
   logic [CLS_W-1:0] rsp_class_ff;
   logic signed [IDX_W-1:0] rsp_idx_ff;
   logic [CNT_W-1:0] rsp_cum_ff, rsp_total_ff, rsp_below_ff, rsp_above_ff, rsp_nonpos_ff;
   logic [63:0] rsp_sum_ff;

   logic [EXP_W-1:0] biased;
   logic nonpos, is_inf;
   logic signed [11:0] e_val;
   logic [FRAC_W-1:0] mant;
   logic [2:0] sub;
   logic signed [IDX_W-1:0] idx_val;
   logic signed [IDX_W-1:0] off_val;
   class_type class_val;
   logic signed [IDX_W:0] lim_ext, hi_val, n_val;
   logic [AW:0] walk_n;
   logic out_free;

   logic ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [CNT_W-1:0] ram_wr_data, ram_rd_data;
   add_req_type add_req;
   add_rsp_type add_rsp;

   always_comb begin
      biased = bits_ff[62:52];
      nonpos = bits_ff[63] || (bits_ff[62:0] == '0) || (biased == EXP_MAX && bits_ff[51:0] != '0);
      is_inf = biased == EXP_MAX;
      if (biased != '0) begin
         e_val = $signed({1'b0, biased}) - 12'sd1022;
         mant = bits_ff[51:0];
      end else begin
         e_val = -12'sd1022 - $signed({6'd0, shift_ff});
         mant = {norm_ff[50:0], 1'b0};
      end
      if (mant >= TH_QUARTER) begin
         sub = 3'd1;
      end else if (mant >= TH_HALF) begin
         sub = 3'd2;
      end else if (mant >= TH_THREE) begin
         sub = 3'd3;
      end else begin
         sub = 3'd4;
      end
      idx_val = $signed({e_val, 2'b00}) - $signed({11'd0, sub});
      off_val = idx_val - MIN_I;
      if (nonpos) begin
         class_val = CLS_NONPOS;
      end else if (is_inf) begin
         class_val = CLS_INF;
      end else if (idx_val < MIN_I) begin
         class_val = CLS_SMALL;
      end else if (idx_val >= MAX_I) begin
         class_val = CLS_LARGE;
      end else begin
         class_val = CLS_BUCKET;
      end
   end

   always_comb begin
      lim_ext = (IDX_W + 1)'(limit_ff);
      hi_val = (lim_ext > (IDX_W + 1)'(MAX_I)) ? (IDX_W + 1)'(MAX_I) : lim_ext;
      n_val = hi_val - (IDX_W + 1)'(MIN_I);
      walk_n = (n_val > 0) ? n_val[AW:0] : '0;
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = state_ff == ST_IDLE;

   always_comb begin
      ram_wr_en = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = ram_rd_data + CNT_W'(1);
      ram_rd_en = 1'b0;
      ram_rd_addr = addr_ff;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en = 1'b1;
         ram_wr_addr = clear_ff[AW-1:0];
         ram_wr_data = '0;
      end else if (state_ff == ST_UPDATE) begin
         ram_wr_en = class_ff == CLS_BUCKET;
      end else if (state_ff == ST_CLASSIFY) begin
         ram_rd_en = 1'b1;
         ram_rd_addr = off_val[AW-1:0];
      end else if (state_ff == ST_WALK) begin
         ram_rd_en = left_ff != '0;
      end
   end

   always_comb begin
      add_req.start = state_ff == ST_CLASSIFY && !nonpos && !is_inf;
      add_req.acc = sum_ff;
      add_req.smp = bits_ff;
   end

   elh_ram #(.WIDTH(CNT_W), .DEPTH(NUM)) u_bucket_ram (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en(ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   elh_fadd u_fadd (
      .clock(clock),
      .reset(reset),
      .add_req(add_req),
      .add_rsp(add_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clear_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
         adding_ff <= 1'b0;
         total_ff <= '0;
         below_ff <= '0;
         above_ff <= '0;
         nonpos_ff <= '0;
         sum_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clear_ff <= clear_ff + (AW + 1)'(1);
               if (clear_ff == NUM_C - (AW + 1)'(1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_chan.valid) begin
                  bits_ff <= req_chan.sample_bits;
                  limit_ff <= req_chan.grid_limit;
                  norm_ff <= req_chan.sample_bits[51:0];
                  shift_ff <= '0;
                  addr_ff <= '0;
                  left_ff <= '0;
                  rd_vld_ff <= 1'b0;
                  if (req_chan.cmd == CMD_QUERY) begin
                     state_ff <= ST_WALK;
                  end else begin
                     state_ff <= ST_NORM;
                  end
               end
            end
            ST_NORM: begin
               if (biased != '0 || norm_ff[51] || norm_ff == '0) begin
                  left_ff <= '0;
                  state_ff <= ST_CLASSIFY;
               end else if (norm_ff[51:44] == '0) begin
                  norm_ff <= norm_ff << 8;
                  shift_ff <= shift_ff + 6'd8;
               end else begin
                  norm_ff <= norm_ff << 1;
                  shift_ff <= shift_ff + 6'd1;
               end
            end
            ST_CLASSIFY: begin
               class_ff <= class_val;
               idx_ff <= (class_val == CLS_NONPOS || class_val == CLS_INF) ? '0 : idx_val;
               addr_ff <= off_val[AW-1:0];
               adding_ff <= add_req.start;
               cum_ff <= '0;
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               total_ff <= total_ff + CNT_W'(1);
               if (class_ff == CLS_NONPOS) begin
                  nonpos_ff <= nonpos_ff + CNT_W'(1);
               end
               if (class_ff == CLS_NONPOS || class_ff == CLS_SMALL) begin
                  below_ff <= below_ff + CNT_W'(1);
               end
               if (class_ff == CLS_INF || class_ff == CLS_LARGE) begin
                  above_ff <= above_ff + CNT_W'(1);
               end
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               if (!adding_ff) begin
                  state_ff <= ST_OUT;
               end else if (add_rsp.done) begin
                  sum_ff <= add_rsp.result;
                  adding_ff <= 1'b0;
                  state_ff <= ST_OUT;
               end
            end
            ST_WALK: begin
               if (!rd_vld_ff && left_ff == '0 && addr_ff == '0 && !adding_ff) begin
                  // first walk cycle: load count and base
                  left_ff <= walk_n;
                  cum_ff <= below_ff;
                  adding_ff <= 1'b1;
               end else begin
                  if (left_ff != '0) begin
                     addr_ff <= addr_ff + AW'(1);
                     left_ff <= left_ff - (AW + 1)'(1);
                  end
                  rd_vld_ff <= left_ff != '0;
                  if (rd_vld_ff) begin
                     cum_ff <= cum_ff + ram_rd_data;
                  end
                  if (left_ff == '0 && !rd_vld_ff) begin
                     adding_ff <= 1'b0;
                     class_ff <= CLS_BUCKET;
                     idx_ff <= '0;
                     state_ff <= ST_OUT;
                  end
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_class_ff <= class_ff;
                  rsp_idx_ff <= idx_ff;
                  rsp_cum_ff <= cum_ff;
                  rsp_total_ff <= total_ff;
                  rsp_below_ff <= below_ff;
                  rsp_above_ff <= above_ff;
                  rsp_nonpos_ff <= nonpos_ff;
                  rsp_sum_ff <= sum_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.sample_class = rsp_class_ff;
   assign rsp_chan.bucket_index = rsp_idx_ff;
   assign rsp_chan.cumulative_count = rsp_cum_ff;
   assign rsp_chan.total_count = rsp_total_ff;
   assign rsp_chan.underflow_count = rsp_below_ff;
   assign rsp_chan.overflow_count = rsp_above_ff;
   assign rsp_chan.nonpositive_count = rsp_nonpos_ff;
   assign rsp_chan.sum_bits = rsp_sum_ff;

`ifndef SYNTH
   a_add_done_expected: assert property (@(posedge clock) disable iff (reset)
      add_rsp.done |-> (adding_ff && state_ff == ST_SUM))
      else $error("adder result without pending add");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_chan.ready)
      else $error("request taken during memory clear");

   a_total_counts_observe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> (total_ff == $past(total_ff) + CNT_W'(1)))
      else $error("total count not raised by observe");

   a_no_response_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> $stable(rsp_total_ff))
      else $error("pending response overwritten");
`endif
endmodule

// ----- src/elh_ram.sv -----
// generic single write port, single read port ram with registered read
module elh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ----- src/elh_fadd.sv -----
// four-stage double adder for two non-negative operands, round to nearest even
module elh_fadd (
   input  logic clock,
   input  logic reset,
   input  elh_pkg::add_req_type add_req,
   output elh_pkg::add_rsp_type add_rsp
);
   import elh_pkg::*;

   logic a_ge;
   logic [63:0] big, sml;
   logic [EXP_W-1:0] ex_big, ex_sml;

   logic vld_a_ff, vld_b_ff, vld_c_ff, done_ff;
   logic inf_a_ff, inf_b_ff, inf_c_ff;
   logic [EXP_W-1:0] ex_a_ff, ex_b_ff, d_a_ff;
   logic [52:0] mx_a_ff, my_a_ff, mx_b_ff;
   logic [55:0] al_b_ff;
   logic [55:0] m_c_ff;
   logic [11:0] e_c_ff;
   logic [63:0] result_ff;

   logic [55:0] ywide, shifted, lost, al_in;
   logic [56:0] sum_c;
   logic [55:0] m_in;
   logic [11:0] e_in;
   logic up;
   logic [53:0] rnd;
   logic [52:0] mant;
   logic [11:0] e_fin;
   logic [63:0] result_in;

   always_comb begin
      a_ge = add_req.acc[62:0] >= add_req.smp[62:0];
      big = a_ge ? add_req.acc : add_req.smp;
      sml = a_ge ? add_req.smp : add_req.acc;
      ex_big = (big[62:52] == '0) ? EXP_W'(1) : big[62:52];
      ex_sml = (sml[62:52] == '0) ? EXP_W'(1) : sml[62:52];
   end

   always_comb begin
      ywide = {my_a_ff, 3'b000};
      shifted = ywide >> d_a_ff[5:0];
      lost = ywide & ~({56{1'b1}} << d_a_ff[5:0]);
      if (d_a_ff >= EXP_W'(56)) begin
         al_in = {55'd0, |my_a_ff};
      end else begin
         al_in = {shifted[55:1], shifted[0] | (|lost)};
      end
   end

   always_comb begin
      sum_c = {1'b0, mx_b_ff, 3'b000} + {1'b0, al_b_ff};
      if (sum_c[56]) begin
         m_in = {sum_c[56:2], sum_c[1] | sum_c[0]};
         e_in = {1'b0, ex_b_ff} + 12'd1;
      end else begin
         m_in = sum_c[55:0];
         e_in = {1'b0, ex_b_ff};
      end
   end

   always_comb begin
      up = m_c_ff[2] & (m_c_ff[3] | m_c_ff[1] | m_c_ff[0]);
      rnd = {1'b0, m_c_ff[55:3]} + 54'(up);
      if (rnd[53]) begin
         mant = rnd[53:1];
         e_fin = e_c_ff + 12'd1;
      end else begin
         mant = rnd[52:0];
         e_fin = e_c_ff;
      end
      if (inf_c_ff || e_fin >= {1'b0, EXP_MAX}) begin
         result_in = POS_INF;
      end else begin
         result_in = {1'b0, mant[52] ? e_fin[10:0] : 11'd0, mant[51:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         vld_a_ff <= add_req.start;
         vld_b_ff <= vld_a_ff;
         vld_c_ff <= vld_b_ff;
         done_ff <= vld_c_ff;
      end
      inf_a_ff <= big[62:52] == EXP_MAX;
      ex_a_ff <= ex_big;
      d_a_ff <= ex_big - ex_sml;
      mx_a_ff <= {big[62:52] != '0, big[51:0]};
      my_a_ff <= {sml[62:52] != '0, sml[51:0]};
      inf_b_ff <= inf_a_ff;
      ex_b_ff <= ex_a_ff;
      mx_b_ff <= mx_a_ff;
      al_b_ff <= al_in;
      inf_c_ff <= inf_b_ff;
      m_c_ff <= m_in;
      e_c_ff <= e_in;
      result_ff <= result_in;
   end

   assign add_rsp.done = done_ff;
   assign add_rsp.result = result_ff;
endmodule

// ----- tb/exponential_latency_histogram_test.sv -----
// self-checking testbench of the exponential latency histogram
module exponential_latency_histogram_test;
   timeunit 1ns;
   timeprecision 1ps;
   import elh_pkg::*;

   localparam int LOW_INDEX = -64;
   localparam int HIGH_INDEX = 64;
   localparam int RANDOM_WORDS = 1250;
   localparam int CALM_WORDS = 200;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      class_type cls;
      logic signed [13:0] idx;
      logic [63:0] cum;
      logic [63:0] total;
      logic [63:0] under;
      logic [63:0] over;
      logic [63:0] nonpos;
      logic [63:0] sum;
   } tally_type;

   typedef struct {
      cmd_type cmd;
      logic [63:0] bits;
      logic signed [8:0] lim;
      bit typed;
      class_type cls;
      int idx;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   elh_req_if req ();
   elh_rsp_if rsp ();

   exponential_latency_histogram dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req),
      .rsp_chan(rsp)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [63:0] bin_count [HIGH_INDEX-LOW_INDEX];
   logic [63:0] seen_total, below_count, above_count, nonpos_count;
   real running_sum;
   tally_type pending [$];
   int faults = 0;
   bit calm = 0;
   bit typed_now = 0;
   class_type typed_cls;
   int typed_idx;
   int quiet_cycles = 0;

   function automatic int octave_index(logic [63:0] bits);
      logic [10:0] biased;
      logic [51:0] frac;
      int e, p;
      real m;
      biased = bits[62:52];
      frac = bits[51:0];
      if (biased != 0) begin
         e = int'(biased) - 1022;
      end else begin
         p = 51;
         while (p > 0 && !frac[p]) p--;
         e = p - 1073;
         frac = frac << (52 - p);
      end
      m = $bitstoreal({12'h3FE, frac});
      if (m >= 0.8408964152537145) return 4 * e - 1;
      if (m >= 0.7071067811865476) return 4 * e - 2;
      if (m >= 0.5946035575013605) return 4 * e - 3;
      return 4 * e - 4;
   endfunction

   function automatic tally_type predict_word(cmd_type cmd, logic [63:0] bits,
                                              logic signed [8:0] lim);
      tally_type t;
      int idx, hi;
      t.cls = CLS_BUCKET;
      t.idx = '0;
      t.cum = '0;
      if (cmd == CMD_OBSERVE) begin
         seen_total++;
         if (bits[63] || bits[62:0] == 0 || (bits[62:52] == EXP_MAX && bits[51:0] != 0)) begin
            nonpos_count++;
            below_count++;
            t.cls = CLS_NONPOS;
         end else if (bits[62:52] == EXP_MAX) begin
            above_count++;
            t.cls = CLS_INF;
         end else begin
            running_sum = running_sum + $bitstoreal(bits);
            idx = octave_index(bits);
            t.idx = idx[13:0];
            if (idx < LOW_INDEX) begin
               below_count++;
               t.cls = CLS_SMALL;
            end else if (idx >= HIGH_INDEX) begin
               above_count++;
               t.cls = CLS_LARGE;
            end else begin
               bin_count[idx-LOW_INDEX]++;
            end
         end
      end else begin
         t.cum = below_count;
         hi = (int'(lim) < HIGH_INDEX) ? int'(lim) : HIGH_INDEX;
         for (int k = LOW_INDEX; k < hi; k++) t.cum += bin_count[k-LOW_INDEX];
      end
      t.total = seen_total;
      t.under = below_count;
      t.over = above_count;
      t.nonpos = nonpos_count;
      t.sum = $realtobits(running_sum);
      return t;
   endfunction

   always @(posedge clock) begin
      tally_type t;
      if (!reset && req.valid && req.ready) begin
         t = predict_word(cmd_type'(req.cmd), req.sample_bits, req.grid_limit);
         if (typed_now) begin
            t.cls = typed_cls;
            t.idx = typed_idx[13:0];
         end
         pending.push_back(t);
      end
   end

   task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         faults++;
         $display("%0t %s expected %h actual %h", $time, name, e, a);
      end
   endtask

   always @(posedge clock) begin
      tally_type t;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending.size() == 0) begin
            faults++;
            $display("%0t unexpected word, expected none actual class %0d", $time,
                     rsp.sample_class);
         end else begin
            t = pending.pop_front();
            check_field("class", 64'(t.cls), 64'(rsp.sample_class));
            check_field("index", 64'(t.idx), 64'(rsp.bucket_index));
            check_field("cumulative", t.cum, rsp.cumulative_count);
            check_field("total", t.total, rsp.total_count);
            check_field("underflow", t.under, rsp.underflow_count);
            check_field("overflow", t.over, rsp.overflow_count);
            check_field("nonpositive", t.nonpos, rsp.nonpositive_count);
            check_field("sum", t.sum, rsp.sum_bits);
         end
      end
   end

   // receiver stall bursts
   int stall_left = 0;
   always @(posedge clock) begin
      if (calm || reset) begin
         rsp.ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp.ready <= 1'b0;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_word(cmd_type cmd, logic [63:0] bits, logic signed [8:0] lim);
      req.valid <= 1'b1;
      req.cmd <= cmd;
      req.sample_bits <= bits;
      req.grid_limit <= lim;
      do @(posedge clock); while (!(req.valid && req.ready));
      if (!calm && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   function automatic logic [63:0] random_sample();
      logic [63:0] b;
      logic [51:0] th;
      int r;
      r = $urandom_range(0, 99);
      b = {$urandom, $urandom};
      if (r < 60) begin
         b[63] = 1'b0;
         b[62:52] = 11'($urandom_range(1005, 1040));
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
               0: th = TH_QUARTER;
               1: th = TH_HALF;
               default: th = TH_THREE;
            endcase
            b[51:0] = th - 52'($urandom_range(0, 1));
         end
      end else if (r < 70) begin
         b[63] = 1'b0;
         b[62:52] = 11'($urandom_range(1, 2040));
      end else if (r < 78) begin
         b[63:52] = '0;
      end else if (r < 86) begin
         case ($urandom_range(0, 4))
            0: b = 64'h0;
            1: b = 64'h8000000000000000;
            2: b[62:52] = EXP_MAX;
            3: b = POS_INF;
            default: b = 64'hFFF0000000000000;
         endcase
      end else if (r < 93) begin
         b[63] = 1'b1;
      end
      return b;
   endfunction

   row_type plan [] = '{
      '{CMD_QUERY,   64'h0, 9'sd0, 1, CLS_BUCKET, 0},
      '{CMD_OBSERVE, 64'h0000000000000000, 9'sd0, 1, CLS_NONPOS, 0},
      '{CMD_OBSERVE, 64'h8000000000000000, 9'sd0, 1, CLS_NONPOS, 0},
      '{CMD_OBSERVE, 64'h7FF8000000000000, 9'sd0, 1, CLS_NONPOS, 0},
      '{CMD_OBSERVE, 64'hFFF0000000000000, 9'sd0, 1, CLS_NONPOS, 0},
      '{CMD_OBSERVE, 64'h7FF0000000000000, 9'sd0, 1, CLS_INF, 0},
      '{CMD_OBSERVE, 64'h3FF0000000000000, 9'sd0, 1, CLS_BUCKET, 0},
      '{CMD_OBSERVE, 64'h4000000000000000, 9'sd0, 1, CLS_BUCKET, 4},
      '{CMD_OBSERVE, 64'h0000000000000001, 9'sd0, 1, CLS_SMALL, -4296},
      '{CMD_OBSERVE, 64'h000FFFFFFFFFFFFF, 9'sd0, 1, CLS_SMALL, -4089},
      '{CMD_OBSERVE, 64'h0010000000000000, 9'sd0, 1, CLS_SMALL, -4088},
      '{CMD_OBSERVE, 64'h3EF0000000000000, 9'sd0, 1, CLS_BUCKET, -64},
      '{CMD_OBSERVE, 64'h3EEFFFFFFFFFFFFF, 9'sd0, 1, CLS_SMALL, -65},
      '{CMD_OBSERVE, 64'h40EFFFFFFFFFFFFF, 9'sd0, 1, CLS_BUCKET, 63},
      '{CMD_OBSERVE, 64'h40F0000000000000, 9'sd0, 1, CLS_LARGE, 64},
      '{CMD_OBSERVE, {12'h3FF, TH_HALF}, 9'sd0, 0, CLS_BUCKET, 0},
      '{CMD_OBSERVE, {12'h3FF, TH_HALF - 52'd1}, 9'sd0, 0, CLS_BUCKET, 0},
      '{CMD_OBSERVE, 64'h3FF8000000000000, 9'sd0, 0, CLS_BUCKET, 0},
      '{CMD_QUERY,   64'h0, -9'sd256, 0, CLS_BUCKET, 0},
      '{CMD_QUERY,   64'h0, -9'sd64, 0, CLS_BUCKET, 0},
      '{CMD_QUERY,   64'h0, 9'sd5, 0, CLS_BUCKET, 0},
      '{CMD_QUERY,   64'h0, 9'sd64, 0, CLS_BUCKET, 0},
      '{CMD_QUERY,   64'h0, 9'sd255, 0, CLS_BUCKET, 0},
      '{CMD_OBSERVE, 64'h7FEFFFFFFFFFFFFF, 9'sd0, 1, CLS_LARGE, 4095},
      '{CMD_OBSERVE, 64'h7FEFFFFFFFFFFFFF, 9'sd0, 1, CLS_LARGE, 4095}
   };

   task automatic send_row(row_type w);
      typed_now <= w.typed;
      typed_cls <= w.cls;
      typed_idx <= w.idx;
      send_word(w.cmd, w.bits, w.lim);
      typed_now <= 1'b0;
   endtask

   initial begin
      req.valid = 1'b0;
      req.cmd = CMD_OBSERVE;
      req.sample_bits = '0;
      req.grid_limit = '0;
      rsp.ready = 1'b0;
      seen_total = '0;
      below_count = '0;
      above_count = '0;
      nonpos_count = '0;
      running_sum = 0.0;
      foreach (bin_count[k]) bin_count[k] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < plan.size() - 2; n++) send_row(plan[n]);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS / 2) begin
            req.valid <= 1'b0;
            while (pending.size() != 0) @(posedge clock);
         end
         if (n == RANDOM_WORDS - CALM_WORDS) calm = 1;
         if ($urandom_range(0, 9) < 7)
            send_word(CMD_OBSERVE, random_sample(), 9'($urandom));
         else if ($urandom_range(0, 1) == 0)
            send_word(CMD_QUERY, {$urandom, $urandom}, 9'($urandom));
         else
            send_word(CMD_QUERY, {$urandom, $urandom}, 9'($urandom_range(0, 140) - 70));
      end
      send_row(plan[plan.size() - 2]);
      send_row(plan[plan.size() - 1]);
      req.valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (faults == 0 && pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
